// ===== rtl/tbl_pkg.sv =====
// tbl_pkg: shared types, codes and character classes for the template lexer.
// Used by every module of the lexer; depends on nothing.
`timescale 1ns / 1ps
package tbl_pkg;

   localparam int MAX_RES = 4;
   localparam int CNT_W   = 3;
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;

   typedef enum logic [3:0] {
      MODE_PLAIN   = 4'd0,
      MODE_BRACE   = 4'd1,
      MODE_BLOCK   = 4'd2,
      MODE_RBRACE  = 4'd3,
      MODE_BANG    = 4'd4,
      MODE_EQUAL   = 4'd5,
      MODE_PLUS    = 4'd6,
      MODE_MINUS   = 4'd7,
      MODE_STRING  = 4'd8,
      MODE_NUMBER  = 4'd9,
      MODE_LESS    = 4'd10,
      MODE_GREATER = 4'd11,
      MODE_IDENT   = 4'd12
   } lex_mode_type;

   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [4:0] TOK_PLAIN  = 5'd0;
   localparam logic [4:0] TOK_BBEGIN = 5'd1;
   localparam logic [4:0] TOK_BEND   = 5'd2;
   localparam logic [4:0] TOK_IDENT  = 5'd3;
   localparam logic [4:0] TOK_STRING = 5'd4;
   localparam logic [4:0] TOK_NUMBER = 5'd5;
   localparam logic [4:0] TOK_ASSIGN = 5'd6;
   localparam logic [4:0] TOK_EQ     = 5'd7;
   localparam logic [4:0] TOK_NOTEQ  = 5'd8;
   localparam logic [4:0] TOK_NOT    = 5'd9;
   localparam logic [4:0] TOK_ADD    = 5'd10;
   localparam logic [4:0] TOK_INC    = 5'd11;
   localparam logic [4:0] TOK_SUB    = 5'd12;
   localparam logic [4:0] TOK_DEC    = 5'd13;
   localparam logic [4:0] TOK_LT     = 5'd14;
   localparam logic [4:0] TOK_LE     = 5'd15;
   localparam logic [4:0] TOK_GT     = 5'd16;
   localparam logic [4:0] TOK_GE     = 5'd17;
   localparam logic [4:0] TOK_RBRACE = 5'd18;
   localparam logic [4:0] TOK_PUNCT  = 5'd19;

   localparam logic [7:0] CH_LBRACE     = 8'h7B;
   localparam logic [7:0] CH_RBRACE     = 8'h7D;
   localparam logic [7:0] CH_QUOTE      = 8'h22;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_BANG       = 8'h21;
   localparam logic [7:0] CH_EQUAL      = 8'h3D;
   localparam logic [7:0] CH_PLUS       = 8'h2B;
   localparam logic [7:0] CH_MINUS      = 8'h2D;
   localparam logic [7:0] CH_LESS       = 8'h3C;
   localparam logic [7:0] CH_GREATER    = 8'h3E;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_char;
      logic [4:0] token_type;
      logic [6:0] token_len;
      logic       last;
   } rsp_word_type;

   // All result words caused by one input byte.
   typedef struct packed {
      logic [CNT_W-1:0]           cnt;
      rsp_word_type [MAX_RES-1:0] ev;
   } bundle_type;

   function automatic logic is_digit(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return c inside {8'h3A, 8'h3B, 8'h2A, 8'h2F, 8'h25, 8'h2E, 8'h28, 8'h29,
                       8'h5B, 8'h5D, 8'h7B};
   endfunction

endpackage

// ===== rtl/tbl_front.sv =====
// tbl_front: accepts input words, runs the lexer state and produces the
// bundle of result words for each byte. Depends on tbl_pkg.
`timescale 1ns / 1ps
module tbl_front #(
   parameter int MAX_TOKEN_LEN = 99
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tbl_pkg::req_word_type req_word,
   output logic                 full,
   input  logic                 q_full,
   output logic                 q_push,
   output tbl_pkg::bundle_type  q_bundle
);

   localparam int KW = $clog2(MAX_TOKEN_LEN + 1);

   typedef struct packed {
      tbl_pkg::lex_mode_type                        mode;
      logic [KW-1:0]                                kept;
      logic [7:0]                                   punct;
      logic [tbl_pkg::CNT_W-1:0]                    cnt;
      tbl_pkg::rsp_word_type [tbl_pkg::MAX_RES-1:0] ev;
   } lex_ctx_type;

   tbl_pkg::lex_mode_type mode_ff, mode_in;
   logic [KW-1:0]         kept_ff, kept_in;
   logic [7:0]            punct_ff, punct_in;
   lex_ctx_type           ctx;
   logic                  accept;

   function automatic lex_ctx_type emit_word(lex_ctx_type st, logic [1:0] kind,
                                             logic [7:0] ch, logic [4:0] ttype,
                                             logic [KW-1:0] len);
      lex_ctx_type r;
      logic [8:0]  wide;
      r    = st;
      wide = 9'(len);
      if (r.cnt < tbl_pkg::CNT_W'(tbl_pkg::MAX_RES)) begin
         r.ev[r.cnt[1:0]].kind       = kind;
         r.ev[r.cnt[1:0]].out_char   = ch;
         r.ev[r.cnt[1:0]].token_type = ttype;
         r.ev[r.cnt[1:0]].token_len  = (wide > 9'd127) ? 7'd127 : wide[6:0];
         r.ev[r.cnt[1:0]].last       = 1'b0;
         r.cnt = r.cnt + tbl_pkg::CNT_W'(1);
      end
      return r;
   endfunction

   function automatic lex_ctx_type push_char(lex_ctx_type st, logic [7:0] c);
      lex_ctx_type r;
      r = st;
      if (9'(r.kept) < 9'(MAX_TOKEN_LEN)) begin
         r.kept = r.kept + KW'(1);
         r = emit_word(r, tbl_pkg::KIND_CHAR, c, tbl_pkg::TOK_PLAIN, r.kept);
      end
      return r;
   endfunction

   function automatic lex_ctx_type finish(lex_ctx_type st, logic [4:0] ttype,
                                          tbl_pkg::lex_mode_type next_mode);
      lex_ctx_type r;
      r = emit_word(st, tbl_pkg::KIND_END,
                    (ttype == tbl_pkg::TOK_PUNCT) ? st.punct : 8'd0,
                    ttype, st.kept);
      r.kept = '0;
      r.mode = next_mode;
      return r;
   endfunction

   function automatic lex_ctx_type block_byte(lex_ctx_type st, logic [7:0] c);
      lex_ctx_type r;
      r = st;
      if (!tbl_pkg::is_space(c)) begin
         case (c)
            tbl_pkg::CH_RBRACE:  r.mode = tbl_pkg::MODE_RBRACE;
            tbl_pkg::CH_BANG:    r.mode = tbl_pkg::MODE_BANG;
            tbl_pkg::CH_EQUAL:   r.mode = tbl_pkg::MODE_EQUAL;
            tbl_pkg::CH_PLUS:    r.mode = tbl_pkg::MODE_PLUS;
            tbl_pkg::CH_MINUS:   r.mode = tbl_pkg::MODE_MINUS;
            tbl_pkg::CH_LESS:    r.mode = tbl_pkg::MODE_LESS;
            tbl_pkg::CH_GREATER: r.mode = tbl_pkg::MODE_GREATER;
            tbl_pkg::CH_QUOTE:   r.mode = tbl_pkg::MODE_STRING;
            default: begin
               if (tbl_pkg::is_digit(c)) begin
                  r.mode = tbl_pkg::MODE_NUMBER;
                  r = push_char(r, c);
               end else if (tbl_pkg::is_punct(c)) begin
                  r.punct = c;
                  r = push_char(r, c);
                  r = finish(r, tbl_pkg::TOK_PUNCT, tbl_pkg::MODE_BLOCK);
               end else if (tbl_pkg::is_alpha(c) || c == tbl_pkg::CH_UNDERSCORE) begin
                  r.mode = tbl_pkg::MODE_IDENT;
                  r = push_char(r, c);
               end else begin
                  r = emit_word(r, tbl_pkg::KIND_ERROR, c, tbl_pkg::TOK_PLAIN, '0);
               end
            end
         endcase
      end
      return r;
   endfunction

   // Pending operator character: pair it with c or end it alone and relex c.
   function automatic lex_ctx_type op_byte(lex_ctx_type st, logic [7:0] c,
                                           logic [7:0] first, logic [7:0] second,
                                           logic [4:0] pair_type,
                                           logic [4:0] single_type,
                                           tbl_pkg::lex_mode_type pair_mode);
      lex_ctx_type r;
      r = push_char(st, first);
      if (c == second) begin
         r = push_char(r, second);
         r = finish(r, pair_type, pair_mode);
      end else begin
         r = finish(r, single_type, tbl_pkg::MODE_BLOCK);
         r = block_byte(r, c);
      end
      return r;
   endfunction

   always_comb begin
      logic [7:0] c;
      c         = req_word.in_byte;
      ctx.mode  = mode_ff;
      ctx.kept  = kept_ff;
      ctx.punct = punct_ff;
      ctx.cnt   = '0;
      ctx.ev    = '0;
      if (req_word.cmd) begin
         if (ctx.kept != '0) begin
            ctx = finish(ctx, tbl_pkg::TOK_PLAIN, tbl_pkg::MODE_PLAIN);
         end
         ctx.mode = tbl_pkg::MODE_PLAIN;
         ctx.kept = '0;
      end else begin
         case (mode_ff)
            tbl_pkg::MODE_BRACE: begin
               if (c == tbl_pkg::CH_LBRACE) begin
                  ctx = finish(ctx, tbl_pkg::TOK_PLAIN, tbl_pkg::MODE_BLOCK);
                  ctx = push_char(ctx, tbl_pkg::CH_LBRACE);
                  ctx = push_char(ctx, tbl_pkg::CH_LBRACE);
                  ctx = finish(ctx, tbl_pkg::TOK_BBEGIN, tbl_pkg::MODE_BLOCK);
               end else begin
                  ctx = push_char(ctx, tbl_pkg::CH_LBRACE);
                  ctx = push_char(ctx, c);
                  ctx.mode = tbl_pkg::MODE_PLAIN;
               end
            end
            tbl_pkg::MODE_BLOCK: ctx = block_byte(ctx, c);
            tbl_pkg::MODE_RBRACE:
               ctx = op_byte(ctx, c, tbl_pkg::CH_RBRACE, tbl_pkg::CH_RBRACE,
                             tbl_pkg::TOK_BEND, tbl_pkg::TOK_RBRACE, tbl_pkg::MODE_PLAIN);
            tbl_pkg::MODE_BANG:
               ctx = op_byte(ctx, c, tbl_pkg::CH_BANG, tbl_pkg::CH_EQUAL,
                             tbl_pkg::TOK_NOTEQ, tbl_pkg::TOK_NOT, tbl_pkg::MODE_BLOCK);
            tbl_pkg::MODE_EQUAL:
               ctx = op_byte(ctx, c, tbl_pkg::CH_EQUAL, tbl_pkg::CH_EQUAL,
                             tbl_pkg::TOK_EQ, tbl_pkg::TOK_ASSIGN, tbl_pkg::MODE_BLOCK);
            tbl_pkg::MODE_PLUS:
               ctx = op_byte(ctx, c, tbl_pkg::CH_PLUS, tbl_pkg::CH_PLUS,
                             tbl_pkg::TOK_INC, tbl_pkg::TOK_ADD, tbl_pkg::MODE_BLOCK);
            tbl_pkg::MODE_MINUS:
               ctx = op_byte(ctx, c, tbl_pkg::CH_MINUS, tbl_pkg::CH_MINUS,
                             tbl_pkg::TOK_DEC, tbl_pkg::TOK_SUB, tbl_pkg::MODE_BLOCK);
            tbl_pkg::MODE_LESS:
               ctx = op_byte(ctx, c, tbl_pkg::CH_LESS, tbl_pkg::CH_EQUAL,
                             tbl_pkg::TOK_LE, tbl_pkg::TOK_LT, tbl_pkg::MODE_BLOCK);
            tbl_pkg::MODE_GREATER:
               ctx = op_byte(ctx, c, tbl_pkg::CH_GREATER, tbl_pkg::CH_EQUAL,
                             tbl_pkg::TOK_GE, tbl_pkg::TOK_GT, tbl_pkg::MODE_BLOCK);
            tbl_pkg::MODE_STRING: begin
               if (c == tbl_pkg::CH_QUOTE) begin
                  ctx = finish(ctx, tbl_pkg::TOK_STRING, tbl_pkg::MODE_BLOCK);
               end else begin
                  ctx = push_char(ctx, c);
               end
            end
            tbl_pkg::MODE_NUMBER: begin
               if (tbl_pkg::is_digit(c)) begin
                  ctx = push_char(ctx, c);
               end else begin
                  ctx = finish(ctx, tbl_pkg::TOK_NUMBER, tbl_pkg::MODE_BLOCK);
                  ctx = block_byte(ctx, c);
               end
            end
            tbl_pkg::MODE_IDENT: begin
               if (tbl_pkg::is_alpha(c) || tbl_pkg::is_digit(c) ||
                   c == tbl_pkg::CH_UNDERSCORE) begin
                  ctx = push_char(ctx, c);
               end else begin
                  ctx = finish(ctx, tbl_pkg::TOK_IDENT, tbl_pkg::MODE_BLOCK);
                  ctx = block_byte(ctx, c);
               end
            end
            default: begin
               if (c == tbl_pkg::CH_LBRACE) begin
                  ctx.mode = tbl_pkg::MODE_BRACE;
               end else begin
                  ctx.mode = tbl_pkg::MODE_PLAIN;
                  ctx = push_char(ctx, c);
               end
            end
         endcase
      end
   end

   assign accept       = push && !q_full;
   assign full         = q_full;
   assign q_push       = accept && (ctx.cnt != '0);
   assign q_bundle.cnt = ctx.cnt;
   assign q_bundle.ev  = ctx.ev;

   assign mode_in  = accept ? ctx.mode  : mode_ff;
   assign kept_in  = accept ? ctx.kept  : kept_ff;
   assign punct_in = accept ? ctx.punct : punct_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= tbl_pkg::MODE_PLAIN;
         kept_ff  <= '0;
         punct_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         kept_ff  <= kept_in;
         punct_ff <= punct_in;
      end
   end

endmodule

// ===== rtl/tbl_queue.sv =====
// tbl_queue: short queue of result bundles between the lexer front and the
// output sequencer. Depends on tbl_pkg.
`timescale 1ns / 1ps
module tbl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  tbl_pkg::bundle_type wr_data,
   output logic                full,
   input  logic                rd_en,
   output tbl_pkg::bundle_type rd_data,
   output logic                empty
);

   tbl_pkg::bundle_type        mem_ff [tbl_pkg::Q_DEPTH];
   logic [tbl_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tbl_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tbl_pkg::Q_PTR_W:0]   count_ff, count_in;
   logic                        do_wr, do_rd;

   assign full    = (count_ff == (tbl_pkg::Q_PTR_W + 1)'(tbl_pkg::Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (tbl_pkg::Q_PTR_W + 1)'(do_wr)
                               - (tbl_pkg::Q_PTR_W + 1)'(do_rd);

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/tbl_back.sv =====
// tbl_back: walks the head bundle's words into the output register, one word
// per cycle while pop keeps up, marking each byte's last word. Depends on tbl_pkg.
`timescale 1ns / 1ps
module tbl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  tbl_pkg::bundle_type   q_head,
   output logic                  q_pop,
   input  logic                  pop,
   output logic                  empty,
   output tbl_pkg::rsp_word_type rsp_word
);

   logic [1:0]            idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   tbl_pkg::rsp_word_type word_ff, word_in;
   logic                  load, is_last;

   assign load    = !q_empty && (!valid_ff || pop);
   assign is_last = ({1'b0, idx_ff} == q_head.cnt - tbl_pkg::CNT_W'(1));
   assign q_pop   = load && is_last;

   always_comb begin
      word_in      = q_head.ev[idx_ff];
      word_in.last = is_last;
      idx_in       = idx_ff;
      valid_in     = valid_ff && !pop;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign empty    = !valid_ff;
   assign rsp_word = word_ff;

endmodule

// ===== rtl/template_block_lexer.sv =====
// template_block_lexer: streaming lexer for template text, top level.
// Instantiates tbl_front, tbl_queue and tbl_back; depends on tbl_pkg.
//
// Usage:
//  - Input is a queue write port: req_word (cmd, in_byte) is taken at a clock
//    edge with push high and full low. cmd = 1 marks end of input.
//  - Results come out of a queue read port: while empty is low, rsp_word holds
//    the oldest word (kind, out_char, token_type, token_len, last); pop takes
//    it. last marks the final word caused by one input word.
//  - A byte may cause zero to four words. The front lexes one byte per cycle
//    while full is low and packs all its words into one bundle; the back sends
//    one word per cycle, while pop keeps up, from a two-bundle queue, so the
//    output port sets the rate.
//  - The first word of a byte passes through the queue and then the output
//    register before it is on rsp_word, when nothing is waiting ahead of it.
//  - When pop stays low the output word holds, the queue fills and full rises
//    once it holds two bundles; bytes that cause no word still wait on full.
//  - Reset (synchronous, active high) puts the lexer in plain text mode with
//    no pending token and empties the queue and output register.
`timescale 1ns / 1ps
module template_block_lexer #(
   parameter int MAX_TOKEN_LEN = 99
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tbl_pkg::req_word_type req_word,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output tbl_pkg::rsp_word_type rsp_word
);

   logic                q_full, q_push, q_empty, q_pop;
   tbl_pkg::bundle_type q_wr_bundle, q_head;

   tbl_front #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .req_word(req_word),
      .full    (full),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_bundle(q_wr_bundle)
   );

   tbl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_push),
      .wr_data(q_wr_bundle),
      .full   (q_full),
      .rd_en  (q_pop),
      .rd_data(q_head),
      .empty  (q_empty)
   );

   tbl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .rsp_word(rsp_word)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("output not empty after reset");

   a_full_queue: assert property (@(posedge clock) disable iff (reset)
      full |-> !q_empty)
      else $error("full raised with an empty queue");

   a_char_len: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.kind == tbl_pkg::KIND_CHAR) |-> rsp_word.token_len != 7'd0)
      else $error("character word with zero length");

   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.kind == tbl_pkg::KIND_ERROR) |->
         (rsp_word.token_type == tbl_pkg::TOK_PLAIN && rsp_word.token_len == 7'd0))
      else $error("error word carries token fields");

   a_pop_bundle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_head.cnt != '0 && !q_empty))
      else $error("bundle dequeued while invalid");

endmodule

// ===== tb/tb_template_block_lexer.sv =====
// tb_template_block_lexer: self-checking testbench for the template lexer.
// Queue-driven stimulus, an in-bench lexer model and a word-by-word scoreboard.
// Depends on tbl_pkg and template_block_lexer.
`timescale 1ns / 1ps
module tb_template_block_lexer;
   import tbl_pkg::*;

   localparam int TOKEN_LIMIT = 99;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_LEN    = 300;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         push = 1'b0;
   logic         pop = 1'b0;
   req_word_type req_word = '0;
   logic         full;
   logic         empty;
   rsp_word_type rsp_word;

   template_block_lexer #(.MAX_TOKEN_LEN(TOKEN_LIMIT)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .req_word(req_word),
      .full    (full),
      .pop     (pop),
      .empty   (empty),
      .rsp_word(rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- lexer model ----------------
   lex_mode_type lx_mode = MODE_PLAIN;
   int           lx_len = 0;
   logic [7:0]   lx_punct = 8'h00;
   rsp_word_type step_words[$];
   rsp_word_type expected_words[$];

   function automatic logic char_is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic char_is_letter(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic char_is_blank(logic [7:0] c);
      return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic char_is_single(logic [7:0] c);
      return (c == ":") || (c == ";") || (c == "*") || (c == "/") || (c == "%") ||
             (c == ".") || (c == "(") || (c == ")") || (c == "[") || (c == "]") ||
             (c == CH_LBRACE);
   endfunction

   task automatic add_word(input logic [1:0] kind, input logic [7:0] ch,
                           input logic [4:0] tt, input int len);
      rsp_word_type w;
      w.kind       = kind;
      w.out_char   = ch;
      w.token_type = tt;
      w.token_len  = (len > 127) ? 7'd127 : len[6:0];
      w.last       = 1'b0;
      if (step_words.size() < MAX_RES) step_words.push_back(w);
   endtask

   task automatic keep_char(input logic [7:0] c);
      if (lx_len < TOKEN_LIMIT) begin
         lx_len++;
         add_word(KIND_CHAR, c, TOK_PLAIN, lx_len);
      end
   endtask

   task automatic close_token(input logic [4:0] tt, input lex_mode_type nxt);
      add_word(KIND_END, (tt == TOK_PUNCT) ? lx_punct : 8'h00, tt, lx_len);
      lx_len  = 0;
      lx_mode = nxt;
   endtask

   task automatic start_token(input logic [7:0] c);
      if (!char_is_blank(c)) begin
         case (c)
            CH_RBRACE:  lx_mode = MODE_RBRACE;
            CH_BANG:    lx_mode = MODE_BANG;
            CH_EQUAL:   lx_mode = MODE_EQUAL;
            CH_PLUS:    lx_mode = MODE_PLUS;
            CH_MINUS:   lx_mode = MODE_MINUS;
            CH_LESS:    lx_mode = MODE_LESS;
            CH_GREATER: lx_mode = MODE_GREATER;
            CH_QUOTE:   lx_mode = MODE_STRING;
            default: begin
               if (char_is_digit(c)) begin
                  lx_mode = MODE_NUMBER;
                  keep_char(c);
               end else if (char_is_single(c)) begin
                  lx_punct = c;
                  keep_char(c);
                  close_token(TOK_PUNCT, MODE_BLOCK);
               end else if (char_is_letter(c) || c == CH_UNDERSCORE) begin
                  lx_mode = MODE_IDENT;
                  keep_char(c);
               end else begin
                  add_word(KIND_ERROR, c, TOK_PLAIN, 0);
               end
            end
         endcase
      end
   endtask

   task automatic pair_or_single(input logic [7:0] c, input logic [7:0] first,
                                 input logic [7:0] second, input logic [4:0] pair_tt,
                                 input logic [4:0] single_tt, input lex_mode_type pair_mode);
      keep_char(first);
      if (c == second) begin
         keep_char(second);
         close_token(pair_tt, pair_mode);
      end else begin
         close_token(single_tt, MODE_BLOCK);
         start_token(c);
      end
   endtask

   task automatic lex_word(input req_word_type w);
      logic [7:0] c;
      c = w.in_byte;
      step_words.delete();
      if (w.cmd) begin
         if (lx_len > 0) close_token(TOK_PLAIN, MODE_PLAIN);
         lx_mode = MODE_PLAIN;
         lx_len  = 0;
      end else begin
         case (lx_mode)
            MODE_BRACE: begin
               if (c == CH_LBRACE) begin
                  close_token(TOK_PLAIN, MODE_BLOCK);
                  keep_char(CH_LBRACE);
                  keep_char(CH_LBRACE);
                  close_token(TOK_BBEGIN, MODE_BLOCK);
               end else begin
                  keep_char(CH_LBRACE);
                  keep_char(c);
                  lx_mode = MODE_PLAIN;
               end
            end
            MODE_BLOCK:   start_token(c);
            MODE_RBRACE:
               pair_or_single(c, CH_RBRACE, CH_RBRACE, TOK_BEND, TOK_RBRACE, MODE_PLAIN);
            MODE_BANG:
               pair_or_single(c, CH_BANG, CH_EQUAL, TOK_NOTEQ, TOK_NOT, MODE_BLOCK);
            MODE_EQUAL:
               pair_or_single(c, CH_EQUAL, CH_EQUAL, TOK_EQ, TOK_ASSIGN, MODE_BLOCK);
            MODE_PLUS:
               pair_or_single(c, CH_PLUS, CH_PLUS, TOK_INC, TOK_ADD, MODE_BLOCK);
            MODE_MINUS:
               pair_or_single(c, CH_MINUS, CH_MINUS, TOK_DEC, TOK_SUB, MODE_BLOCK);
            MODE_LESS:
               pair_or_single(c, CH_LESS, CH_EQUAL, TOK_LE, TOK_LT, MODE_BLOCK);
            MODE_GREATER:
               pair_or_single(c, CH_GREATER, CH_EQUAL, TOK_GE, TOK_GT, MODE_BLOCK);
            MODE_STRING: begin
               if (c == CH_QUOTE) close_token(TOK_STRING, MODE_BLOCK);
               else keep_char(c);
            end
            MODE_NUMBER: begin
               if (char_is_digit(c)) begin
                  keep_char(c);
               end else begin
                  close_token(TOK_NUMBER, MODE_BLOCK);
                  start_token(c);
               end
            end
            MODE_IDENT: begin
               if (char_is_letter(c) || char_is_digit(c) || c == CH_UNDERSCORE) begin
                  keep_char(c);
               end else begin
                  close_token(TOK_IDENT, MODE_BLOCK);
                  start_token(c);
               end
            end
            default: begin
               if (c == CH_LBRACE) begin
                  lx_mode = MODE_BRACE;
               end else begin
                  lx_mode = MODE_PLAIN;
                  keep_char(c);
               end
            end
         endcase
      end
      if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   // ---------------- handshake bookkeeping ----------------
   req_word_type pending_items[$];
   int           tx_idle_max = 6;
   int           rx_idle_max = 6;
   int           hold_request = 0;
   int           tx_gap = 0;
   int           rx_gap = 0;
   int           rx_hold = 0;
   logic         req_taken = 1'b0;
   logic         rsp_taken = 1'b0;
   logic         nxt_push;
   logic         nxt_pop;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   rsp_word_type exp_word;

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && push && !full) begin
         lex_word(req_word);
         req_taken = 1'b1;
      end
      if (!reset && pop && !empty) begin
         rsp_taken = 1'b1;
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: kind=%0d char=%02h type=%0d len=%0d last=%0d",
                        rsp_word.kind, rsp_word.out_char, rsp_word.token_type,
                        rsp_word.token_len, rsp_word.last);
         end else begin
            exp_word = expected_words.pop_front();
            if (rsp_word.kind !== exp_word.kind || rsp_word.out_char !== exp_word.out_char ||
                rsp_word.token_type !== exp_word.token_type ||
                rsp_word.token_len !== exp_word.token_len || rsp_word.last !== exp_word.last)
            begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("mismatch: exp kind=%0d char=%02h type=%0d len=%0d last=%0d",
                         exp_word.kind, exp_word.out_char, exp_word.token_type,
                         exp_word.token_len, exp_word.last);
                  $display(" | got kind=%0d char=%02h type=%0d len=%0d last=%0d",
                           rsp_word.kind, rsp_word.out_char, rsp_word.token_type,
                           rsp_word.token_len, rsp_word.last);
               end
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Sender: one word per accepted item, random gap after each.
   always @(negedge clock) begin
      nxt_push = push;
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            nxt_push  = 1'b0;
            tx_gap    = $urandom_range(0, tx_idle_max);
         end
         if (!nxt_push) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (pending_items.size() > 0) begin
               req_word <= pending_items.pop_front();
               nxt_push = 1'b1;
            end
         end
      end
      push <= nxt_push;
   end

   // Receiver: random gap after each word, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      nxt_pop = 1'b0;
      if (!reset) begin
         if (hold_request > 0) begin
            rx_hold      = hold_request;
            hold_request = 0;
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rx_gap    = $urandom_range(0, rx_idle_max);
         end
         if (rx_hold > 0) rx_hold--;
         else if (rx_gap > 0) rx_gap--;
         else nxt_pop = 1'b1;
      end
      pop <= nxt_pop;
   end

   // ---------------- stimulus ----------------
   int items_queued = 0;

   task automatic queue_byte(input logic [7:0] b);
      req_word_type w;
      w.cmd     = 1'b0;
      w.in_byte = b;
      pending_items.push_back(w);
      items_queued++;
   endtask

   task automatic queue_end(input logic [7:0] b);
      req_word_type w;
      w.cmd     = 1'b1;
      w.in_byte = b;
      pending_items.push_back(w);
      items_queued++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'h61 + r[7:0];
      else if (r < 52) return 8'h41 + r[7:0] - 8'd26;
      else return CH_UNDERSCORE;
   endfunction

   function automatic logic [7:0] pick_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   task automatic queue_ident(input int len);
      logic [7:0] c;
      queue_byte(pick_letter());
      for (int i = 1; i < len; i++) begin
         c = ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter();
         queue_byte(c);
      end
   endtask

   task automatic queue_token();
      logic [7:0] c;
      int         len;
      case ($urandom_range(0, 9))
         0, 1: queue_ident($urandom_range(1, 8));
         2: begin
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) queue_byte(pick_digit());
         end
         3: begin
            queue_byte(CH_QUOTE);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               c = 8'($urandom_range(0, 255));
               if (c == CH_QUOTE) c = "q";
               queue_byte(c);
            end
            queue_byte(CH_QUOTE);
         end
         4, 5: begin
            case ($urandom_range(0, 5))
               0: queue_byte(CH_BANG);
               1: queue_byte(CH_EQUAL);
               2: queue_byte(CH_PLUS);
               3: queue_byte(CH_MINUS);
               4: queue_byte(CH_LESS);
               default: queue_byte(CH_GREATER);
            endcase
            if ($urandom_range(0, 1) == 0)
               queue_byte(($urandom_range(0, 1) == 0) ? CH_EQUAL : pending_items[$].in_byte);
         end
         6: begin
            case ($urandom_range(0, 10))
               0: queue_byte(":");
               1: queue_byte(";");
               2: queue_byte("*");
               3: queue_byte("/");
               4: queue_byte("%");
               5: queue_byte(".");
               6: queue_byte("(");
               7: queue_byte(")");
               8: queue_byte("[");
               9: queue_byte("]");
               default: queue_byte(CH_LBRACE);
            endcase
         end
         7: queue_byte(CH_RBRACE);
         8: begin
            case ($urandom_range(0, 3))
               0: queue_byte("~");
               1: queue_byte("@");
               2: queue_byte(8'($urandom_range(128, 255)));
               default: queue_byte(8'($urandom_range(0, 8)));
            endcase
         end
         default: begin
            case ($urandom_range(0, 3))
               0: queue_byte(" ");
               1: queue_byte(8'h09);
               2: queue_byte(8'h0A);
               default: queue_byte(8'($urandom_range(11, 13)));
            endcase
         end
      endcase
      if ($urandom_range(0, 1) == 0) queue_byte(" ");
   endtask

   task automatic queue_random(input int n);
      int target;
      int len;
      int sel;
      logic [7:0] c;
      target = items_queued + n;
      while (items_queued < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            queue_byte(8'($urandom_range(0, 255)));
         end else if (sel < 13) begin
            queue_end(8'($urandom_range(0, 255)));
         end else if (sel < 33) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(32, 126));
               queue_byte(c);
            end
         end else begin
            queue_byte(CH_LBRACE);
            queue_byte(CH_LBRACE);
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) queue_token();
            if ($urandom_range(0, 9) < 8) begin
               queue_byte(CH_RBRACE);
               queue_byte(CH_RBRACE);
            end else if ($urandom_range(0, 1) == 0) begin
               queue_end(8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() > 0 || push || expected_words.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: brace cases, the ==, !=, <=, >= and ++ operator pairings, strings, errors, end of input
      tx_idle_max = 6;
      rx_idle_max = 6;
      queue_text("{b{{ x1==-7;\"s\"!=<=>=++!}~}}");
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_text("ab");
      queue_end(8'hA5);
      wait_drained();

      // back to back, with one token past the length limit
      tx_idle_max = 0;
      rx_idle_max = 0;
      queue_text("{{");
      queue_ident(103);
      queue_text("}}");
      queue_random(80);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      tx_idle_max = 6;
      rx_idle_max = 6;
      hold_request = HOLD_LEN;
      queue_random(80);
      wait_drained();

      tx_idle_max = 0;
      rx_idle_max = 6;
      queue_random(20);
      wait_drained();

      tx_idle_max = 6;
      rx_idle_max = 0;
      queue_random(20);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
